// ===== sv/frct_pkg.sv =====
// ----------------------------------------------------------------------------
// frct_pkg
// Shared operation and status codes of the fullness-ranked capacity table.
// ----------------------------------------------------------------------------
package frct_pkg;

    // operation codes carried by an input item
    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_UPDATE   = 2'd1,
        OP_QUERY    = 2'd2
    } t_op;

    // status codes returned with every result item
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2
    } t_status;

    // widths of the item fields
    localparam int unsigned OP_W    = 2;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned PROD_W  = 2 * VAL_W;

endpackage

// ===== sv/fullness_ranked_capacity_table.sv =====
// ----------------------------------------------------------------------------
// fullness_ranked_capacity_table
// Table of capacity / live-count entries, ranked fullest first on query.
// ----------------------------------------------------------------------------
// Usage:
// - input channel (i_in_valid / o_in_ready) takes one item: register a new
//   entry, update the live count of a slot, or query the entry at a rank
// - output channel (o_out_valid / i_out_ready) returns exactly one item per
//   input item, in order, from an output register
// - register and update finish in the accept cycle; the result shows in the
//   next cycle
// - a query with n registered entries walks every candidate slot against
//   every slot with one shared 32x32 multiplier: a read step per candidate,
//   then two products and a compare per pair
// - fullness is compared exactly as live_a * cap_b against live_b * cap_a;
//   ties keep registration order and a zero capacity ranks as empty
// - one item is in work at a time; o_in_ready is low during a query, and
//   also while a result waits in the output register and is not being taken
// - a stalled receiver holds the result; the block waits and loses nothing
// - reset empties the table (entry count zero); stored entries are not cleared
// ----------------------------------------------------------------------------
module fullness_ranked_capacity_table #(
    parameter int unsigned ENTRIES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [frct_pkg::OP_W-1:0]      i_operation,
    input  logic [frct_pkg::IDX_W-1:0]     i_entry_index,
    input  logic [frct_pkg::VAL_W-1:0]     i_capacity,
    input  logic [frct_pkg::VAL_W-1:0]     i_live_value,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [frct_pkg::STAT_W-1:0]    o_status,
    output logic [frct_pkg::IDX_W-1:0]     o_slot,
    output logic [frct_pkg::VAL_W-1:0]     o_capacity_out,
    output logic [frct_pkg::VAL_W-1:0]     o_live_out,
    output logic [frct_pkg::COUNT_W-1:0]   o_entry_count
);

    import frct_pkg::*;

    localparam int unsigned IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW   = $clog2(ENTRIES + 1);
    localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;
    localparam int unsigned SW   = (IW > IDX_W) ? IW : IDX_W;
    localparam int unsigned EW   = (CW > COUNT_W) ? CW : COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL1,
        S_MUL2,
        S_CMP,
        S_FOUND
    } t_state;

    // entry stores
    logic [VAL_W-1:0] cap_mem  [ENTRIES];
    logic [VAL_W-1:0] live_mem [ENTRIES];

    // control state
    t_state          r_state,     n_state;
    logic [CW-1:0]   r_count,     n_count;
    logic [IW-1:0]   r_rank,      n_rank;
    logic [IW-1:0]   r_k,         n_k;
    logic [IW-1:0]   r_j,         n_j;
    logic [IW-1:0]   r_cnt,       n_cnt;
    logic            r_last,      n_last;
    logic            r_jlt,       n_jlt;
    logic [PROD_W-1:0] r_prod_a,  n_prod_a;
    logic [PROD_W-1:0] r_prod_b,  n_prod_b;

    // registered read data
    logic [VAL_W-1:0] r_rd_cap_k, r_rd_live_k, r_rd_cap_j, r_rd_live_j;

    // output register
    logic             r_out_valid, n_out_valid;
    t_status          r_status,    n_status;
    logic [IDX_W-1:0] r_slot,      n_slot;
    logic [VAL_W-1:0] r_cap_out,   n_cap_out;
    logic [VAL_W-1:0] r_live_out,  n_live_out;
    logic [COUNT_W-1:0] r_entry_count, n_entry_count;

    // memory write controls
    logic             we_cap, we_live;
    logic [IW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_live;

    // handshake
    logic out_free, in_fire;
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_fire    = i_in_valid && o_in_ready;

    // index checks
    logic [CMPW-1:0] idx_ext, count_ext;
    logic            idx_ok;
    assign idx_ext   = CMPW'(i_entry_index);
    assign count_ext = CMPW'(r_count);
    assign idx_ok    = idx_ext < count_ext;

    // zero capacity ranks as live 0 over capacity 1
    logic [VAL_W-1:0] norm_live_k, norm_cap_k, norm_live_j, norm_cap_j;
    assign norm_live_k = (r_rd_cap_k == '0) ? '0 : r_rd_live_k;
    assign norm_cap_k  = (r_rd_cap_k == '0) ? VAL_W'(1) : r_rd_cap_k;
    assign norm_live_j = (r_rd_cap_j == '0) ? '0 : r_rd_live_j;
    assign norm_cap_j  = (r_rd_cap_j == '0) ? VAL_W'(1) : r_rd_cap_j;

    // shared multiplier: live_j * cap_k first, then live_k * cap_j
    logic [VAL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    assign mul_a = (r_state == S_MUL1) ? norm_live_j : norm_live_k;
    assign mul_b = (r_state == S_MUL1) ? norm_cap_k  : norm_cap_j;
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // slot j outranks candidate k when fuller, or equally full and earlier
    logic ahead;
    assign ahead = (r_prod_a > r_prod_b) || ((r_prod_a == r_prod_b) && r_jlt);

    logic [IW-1:0] cnt_next;
    assign cnt_next = ahead ? r_cnt + 1'b1 : r_cnt;

    // field widening helpers
    logic [SW-1:0] slot_ext_wr, slot_ext_k, slot_ext_idx;
    logic [EW-1:0] count_inc_ext, count_cur_ext;
    assign slot_ext_wr   = SW'(r_count[IW-1:0]);
    assign slot_ext_k    = SW'(r_k);
    assign slot_ext_idx  = SW'(idx_ext[IW-1:0]);
    assign count_inc_ext = EW'(r_count + 1'b1);
    assign count_cur_ext = EW'(r_count);

    // next-state logic
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_rank        = r_rank;
        n_k           = r_k;
        n_j           = r_j;
        n_cnt         = r_cnt;
        n_last        = r_last;
        n_jlt         = r_jlt;
        n_prod_a      = r_prod_a;
        n_prod_b      = r_prod_b;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_status      = r_status;
        n_slot        = r_slot;
        n_cap_out     = r_cap_out;
        n_live_out    = r_live_out;
        n_entry_count = r_entry_count;
        we_cap        = 1'b0;
        we_live       = 1'b0;
        wr_addr       = r_count[IW-1:0];
        wr_live       = i_live_value;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    // default result: bad index, nothing changes
                    n_out_valid   = 1'b1;
                    n_status      = ST_BAD_INDEX;
                    n_slot        = '0;
                    n_cap_out     = '0;
                    n_live_out    = '0;
                    n_entry_count = count_cur_ext[COUNT_W-1:0];
                    case (t_op'(i_operation))
                        OP_REGISTER: begin
                            if (r_count == CW'(ENTRIES)) begin
                                n_status = ST_FULL;
                            end else begin
                                we_cap        = 1'b1;
                                we_live       = 1'b1;
                                n_count       = r_count + 1'b1;
                                n_status      = ST_OK;
                                n_slot        = slot_ext_wr[IDX_W-1:0];
                                n_entry_count = count_inc_ext[COUNT_W-1:0];
                            end
                        end
                        OP_UPDATE: begin
                            if (idx_ok) begin
                                we_live  = 1'b1;
                                wr_addr  = idx_ext[IW-1:0];
                                n_status = ST_OK;
                                n_slot   = slot_ext_idx[IDX_W-1:0];
                            end
                        end
                        OP_QUERY: begin
                            if (idx_ok) begin
                                n_out_valid = 1'b0;
                                n_rank      = idx_ext[IW-1:0];
                                n_k         = '0;
                                n_j         = '0;
                                n_cnt       = '0;
                                n_state     = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                // read data for slots k and j lands at this edge
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_prod_a = mul_p;
                n_state  = S_MUL2;
            end
            S_MUL2: begin
                n_prod_b = mul_p;
                n_jlt    = r_j < r_k;
                n_last   = CW'(r_j) == (r_count - 1'b1);
                // next slot j is read during the compare cycle
                if (CW'(r_j) != (r_count - 1'b1)) begin
                    n_j = r_j + 1'b1;
                end
                n_state = S_CMP;
            end
            S_CMP: begin
                if (!r_last) begin
                    n_cnt   = cnt_next;
                    n_state = S_MUL1;
                end else if (cnt_next == r_rank) begin
                    n_state = S_FOUND;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_j     = '0;
                    n_cnt   = '0;
                    n_state = S_READ;
                end
            end
            S_FOUND: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_status      = ST_OK;
                    n_slot        = slot_ext_k[IDX_W-1:0];
                    n_cap_out     = r_rd_cap_k;
                    n_live_out    = r_rd_live_k;
                    n_entry_count = count_cur_ext[COUNT_W-1:0];
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rank      <= '0;
            r_k         <= '0;
            r_j         <= '0;
            r_cnt       <= '0;
            r_last      <= 1'b0;
            r_jlt       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_rank      <= n_rank;
            r_k         <= n_k;
            r_j         <= n_j;
            r_cnt       <= n_cnt;
            r_last      <= n_last;
            r_jlt       <= n_jlt;
        end
        r_prod_a      <= n_prod_a;
        r_prod_b      <= n_prod_b;
        r_status      <= n_status;
        r_slot        <= n_slot;
        r_cap_out     <= n_cap_out;
        r_live_out    <= n_live_out;
        r_entry_count <= n_entry_count;
    end

    // entry stores: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (we_cap) begin
            cap_mem[wr_addr] <= i_capacity;
        end
        if (we_live) begin
            live_mem[wr_addr] <= wr_live;
        end
        r_rd_cap_k  <= cap_mem[r_k];
        r_rd_live_k <= live_mem[r_k];
        r_rd_cap_j  <= cap_mem[r_j];
        r_rd_live_j <= live_mem[r_j];
    end

    // outputs
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_slot         = r_slot;
    assign o_capacity_out = r_cap_out;
    assign o_live_out     = r_live_out;
    assign o_entry_count  = r_entry_count;

endmodule
